/* design/zrt_pkg.sv */
// Package for the zigzag row transposition block.
// Holds the controller states, command/status structs and fixed constants.
// No dependencies.
`default_nettype none

package zrt_pkg;

	// fixed field widths
	localparam int unsigned DATA_W = 8;
	localparam int unsigned ROWS_W = 7;

	// register file
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;
	localparam logic        REG_NUM_ROWS = 1'b0;  // word index of num_rows
	localparam logic [ROWS_W-1:0] NUM_ROWS_RESET = 7'd1;

	// controller states
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SETUP,
		ST_READ,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic wr_byte;  // store or drop the accepted byte
		logic start;    // set up the burst walk
		logic rd;       // read buffer at the walk position
		logic advance;  // output beat taken, step the walk
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic zero_burst;  // nothing to emit for this string
		logic burst_end;   // current position is the final one
	} status_t;

endpackage

`default_nettype wire

/* design/zrt_ctrl.sv */
// Controller state machine for the zigzag row transposition block.
// Sequences load, burst setup, buffer read and output beats.
// Depends on zrt_pkg.
`default_nettype none

module zrt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             end_of_string,
	input  wire logic             out_stall,
	input  wire zrt_pkg::status_t status,
	output logic                  in_stall,
	output logic                  out_valid,
	output zrt_pkg::cmd_t         cmd
);

	zrt_pkg::state_t state_q;
	zrt_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= zrt_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			zrt_pkg::ST_LOAD: begin
				if (in_valid && end_of_string) begin
					state_d = zrt_pkg::ST_SETUP;
				end
			end
			zrt_pkg::ST_SETUP: begin
				state_d = status.zero_burst ? zrt_pkg::ST_LOAD : zrt_pkg::ST_READ;
			end
			zrt_pkg::ST_READ: begin
				state_d = zrt_pkg::ST_OUT;
			end
			zrt_pkg::ST_OUT: begin
				if (!out_stall) begin
					state_d = status.burst_end ? zrt_pkg::ST_LOAD : zrt_pkg::ST_READ;
				end
			end
			default: state_d = zrt_pkg::ST_LOAD;
		endcase
	end

	// outputs and commands
	always_comb begin
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		cmd         = '0;
		unique case (state_q)
			zrt_pkg::ST_LOAD: begin
				in_stall    = 1'b0;
				cmd.wr_byte = in_valid;
			end
			zrt_pkg::ST_SETUP: begin
				cmd.start = 1'b1;
			end
			zrt_pkg::ST_READ: begin
				cmd.rd = 1'b1;
			end
			zrt_pkg::ST_OUT: begin
				out_valid   = 1'b1;
				cmd.advance = !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/zrt_dp.sv */
// Datapath for the zigzag row transposition block: byte buffer, fill count,
// overflow flag and the rail walker that generates read positions.
// Depends on zrt_pkg.
`default_nettype none

module zrt_dp #(
	parameter int unsigned MAX_LEN = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire zrt_pkg::cmd_t                cmd,
	input  wire logic [zrt_pkg::DATA_W-1:0]   char_in,
	input  wire logic [zrt_pkg::ROWS_W-1:0]   num_rows,
	output zrt_pkg::status_t                  status,
	output logic [zrt_pkg::DATA_W-1:0]        char_out,
	output logic                              last_out,
	output logic                              truncated
);

	localparam int unsigned CW = $clog2(MAX_LEN + 1);  // count and rail width
	localparam int unsigned AW = $clog2(MAX_LEN);      // buffer address width
	localparam int unsigned PW = CW + 1;               // period width
	localparam int unsigned NW = CW + 2;               // next position width
	localparam int unsigned KW = 8;                    // rails compare width

	logic [zrt_pkg::DATA_W-1:0] mem_q [MAX_LEN];
	logic [zrt_pkg::DATA_W-1:0] rdata_q;

	logic [CW-1:0] count_q;
	logic          overflow_q;
	logic [CW-1:0] rails_q;
	logic [PW-1:0] period_q;
	logic [CW-1:0] rail_q;
	logic [AW-1:0] pos_q;
	logic          phase_q;

	logic          room;
	logic [CW-1:0] rails_d;
	logic [PW-1:0] period_d;
	logic [PW-1:0] two_r;
	logic [PW-1:0] step_sel;
	logic [PW-1:0] step;
	logic [NW-1:0] next_pos;
	logic [CW-1:0] rail_next;
	logic          more_in_rail;
	logic          more_rails;

	assign room = (count_q < CW'(MAX_LEN));

	// rails are clamped to the string length
	always_comb begin
		if (KW'(num_rows) < KW'(count_q)) begin
			rails_d = CW'(num_rows);
		end else begin
			rails_d = count_q;
		end
		period_d = (rails_d > CW'(1)) ? ({rails_d, 1'b0} - PW'(2)) : PW'(1);
	end

	// walk steps alternate between period-2r and 2r; a zero step means edge rail
	always_comb begin
		two_r        = {rail_q, 1'b0};
		step_sel     = phase_q ? two_r : (period_q - two_r);
		step         = (step_sel == '0) ? period_q : step_sel;
		next_pos     = NW'(pos_q) + NW'(step);
		more_in_rail = (next_pos < NW'(count_q));
		rail_next    = rail_q + CW'(1);
		more_rails   = (rail_next < rails_q);
	end

	assign status.zero_burst = (num_rows == '0) || (count_q == '0);
	assign status.burst_end  = !more_in_rail && !more_rails;

	// buffer write and registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_byte && room) begin
			mem_q[count_q[AW-1:0]] <= char_in;
		end
		if (cmd.rd) begin
			rdata_q <= mem_q[pos_q];
		end
	end

	// fill count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.wr_byte) begin
			if (room) begin
				count_q <= count_q + CW'(1);
			end else begin
				overflow_q <= 1'b1;
			end
		end else if ((cmd.start && status.zero_burst) ||
		             (cmd.advance && status.burst_end)) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end
	end

	// rail walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rails_q  <= '0;
			period_q <= '0;
			rail_q   <= '0;
			pos_q    <= '0;
			phase_q  <= 1'b0;
		end else if (cmd.start) begin
			rails_q  <= rails_d;
			period_q <= period_d;
			rail_q   <= '0;
			pos_q    <= '0;
			phase_q  <= 1'b0;
		end else if (cmd.advance) begin
			if (more_in_rail) begin
				pos_q   <= next_pos[AW-1:0];
				phase_q <= !phase_q;
			end else if (more_rails) begin
				rail_q  <= rail_next;
				pos_q   <= rail_next[AW-1:0];
				phase_q <= 1'b0;
			end
		end
	end

	assign char_out  = rdata_q;
	assign last_out  = status.burst_end;
	assign truncated = overflow_q;

endmodule

`default_nettype wire

/* design/zigzag_row_transposition_top.sv */
// After the end-marked beat the controller enters setup, which returns to loading
// for an empty burst; each output beat is a buffer read, then a present state held
// while out_stall is high. One input byte per cycle while loading; output beats are
// not back to back, as each needs a registered read. Input stalls during a burst.
// Reset clears control state and sets num_rows to 1; buffer contents are undefined.
`default_nettype none

module zigzag_row_transposition_top #(
	parameter int unsigned MAX_LEN = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [zrt_pkg::DATA_W-1:0]        char_in,
	input  wire logic                              end_of_string,
	// output channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [zrt_pkg::DATA_W-1:0]             char_out,
	output logic                                   last_out,
	output logic                                   truncated,
	// configuration port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [zrt_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [zrt_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [zrt_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                   pready
);

	logic [zrt_pkg::ROWS_W-1:0] num_rows_q;
	logic                       reg_sel;
	zrt_pkg::cmd_t              cmd;
	zrt_pkg::status_t           status;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == zrt_pkg::REG_NUM_ROWS);

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= zrt_pkg::NUM_ROWS_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			num_rows_q <= pwdata[zrt_pkg::ROWS_W-1:0];
		end
	end

	// register read
	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = zrt_pkg::APB_DATA_W'(num_rows_q);
		end
	end

	zrt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.end_of_string (end_of_string),
		.out_stall     (out_stall),
		.status        (status),
		.in_stall      (in_stall),
		.out_valid     (out_valid),
		.cmd           (cmd)
	);

	zrt_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.char_in   (char_in),
		.num_rows  (num_rows_q),
		.status    (status),
		.char_out  (char_out),
		.last_out  (last_out),
		.truncated (truncated)
	);

`ifndef SYNTHESIS
	// no input beat is taken while a result is on offer
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted during output beat");

	// the final beat ends the burst
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_out) |=> (!out_valid && !in_stall))
		else $error("burst continued past last beat");

	// the overflow mark holds across one burst
	a_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_out) |=> $stable(truncated))
		else $error("truncated changed within a burst");

	// a taken non-final beat is followed by a read cycle, never a back-to-back beat
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_out) |=> (!out_valid ##1 out_valid))
		else $error("output walk did not resume");
`endif

endmodule

`default_nettype wire

/* tb/zigzag_row_transposition_top_tb.sv */
// Testbench for zigzag_row_transposition_top: byte strings in, rail-fence reordered bytes out.
// Predicts every burst with its own rail model and checks each output beat in order.
// Depends on zrt_pkg and the top module only.
`default_nettype none

module zigzag_row_transposition_top_tb;

	localparam int MAX_LEN = 64;
	localparam int SETTLE_CYCLES = 160;  // settle wait after drain: covers the longest burst, plus margin
	localparam int REPORT_LIMIT = 10;
	localparam logic [zrt_pkg::APB_ADDR_W-1:0] ADDR_NUM_ROWS =
		zrt_pkg::APB_ADDR_W'(4 * zrt_pkg::REG_NUM_ROWS);

	typedef struct {
		logic [zrt_pkg::DATA_W-1:0] ch;
		logic eos;
	} text_byte_t;

	typedef struct {
		logic [zrt_pkg::DATA_W-1:0] ch;
		logic last;
		logic trunc;
	} rail_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [zrt_pkg::DATA_W-1:0] char_in = '0;
	logic end_of_string = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [zrt_pkg::DATA_W-1:0] char_out;
	logic last_out;
	logic truncated;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [zrt_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [zrt_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [zrt_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	// pending string bytes and expected transposed bytes
	text_byte_t text_q[$];
	rail_byte_t rail_q[$];

	// shadow of the block state
	logic [zrt_pkg::DATA_W-1:0] str_buf [MAX_LEN];
	int unsigned str_len = 0;
	logic str_dropped = 1'b0;
	logic [zrt_pkg::ROWS_W-1:0] rows_shadow = zrt_pkg::NUM_ROWS_RESET;

	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	logic in_taken = 1'b0;
	logic [zrt_pkg::APB_DATA_W-1:0] cfg_readback = '0;

	int unsigned mismatches = 0;
	int unsigned strings_sent = 0;
	int unsigned bytes_taken = 0;
	int unsigned bytes_out = 0;
	int unsigned overflow_strings = 0;
	int unsigned rail_settings = 0;

	zigzag_row_transposition_top #(
		.MAX_LEN(MAX_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_in(char_in),
		.end_of_string(end_of_string),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_out(char_out),
		.last_out(last_out),
		.truncated(truncated),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Store one byte; on the end marker, lay out the zigzag and queue it rail by rail.
	function automatic void rail_fence_predict(input logic [zrt_pkg::DATA_W-1:0] ch,
			input logic eos);
		int unsigned rails;
		int unsigned period;
		int unsigned m;
		rail_byte_t burst[$];
		rail_byte_t rb;
		if (str_len < MAX_LEN) begin
			str_buf[str_len] = ch;
			str_len++;
		end else begin
			str_dropped = 1'b1;
		end
		if (!eos)
			return;
		if (rows_shadow != 0 && str_len != 0) begin
			rails = rows_shadow;
			if (rails > str_len)
				rails = str_len;
			period = (rails > 1) ? 2 * rails - 2 : 1;
			for (int unsigned r = 0; r < rails; r++) begin
				for (int unsigned i = 0; i < str_len; i++) begin
					m = i % period;
					if (m == r || m == period - r) begin
						rb.ch = str_buf[i];
						rb.last = 1'b0;
						rb.trunc = str_dropped;
						burst.push_back(rb);
					end
				end
			end
			burst[burst.size() - 1].last = 1'b1;
			foreach (burst[k])
				rail_q.push_back(burst[k]);
		end
		if (str_dropped)
			overflow_strings++;
		str_len = 0;
		str_dropped = 1'b0;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] expv,
			input logic [31:0] gotv);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch on %s: expected 0x%0h, got 0x%0h", what, expv, gotv);
	endtask

	// Take input beats and feed them to the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			rail_fence_predict(char_in, end_of_string);
			bytes_taken++;
			in_taken <= 1'b1;
		end else begin
			in_taken <= 1'b0;
		end
	end

	// Drive the next pending byte once the current beat is taken; hold it while stalled
	always @(negedge clk) begin : text_driver
		text_byte_t nb;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (text_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				nb = text_q.pop_front();
				in_valid <= 1'b1;
				char_in <= nb.ch;
				end_of_string <= nb.eos;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// Check each output beat against the oldest expected byte
	always @(posedge clk) begin : rail_monitor
		rail_byte_t eb;
		if (arst_n && out_valid && !out_stall) begin
			bytes_out++;
			if (rail_q.size() == 0) begin
				note_mismatch("unexpected output beat", 32'h0, {24'h0, char_out});
			end else begin
				eb = rail_q.pop_front();
				if (char_out !== eb.ch)
					note_mismatch("char_out", {24'h0, eb.ch}, {24'h0, char_out});
				if (last_out !== eb.last)
					note_mismatch("last_out", {31'h0, eb.last}, {31'h0, last_out});
				if (truncated !== eb.trunc)
					note_mismatch("truncated", {31'h0, eb.trunc}, {31'h0, truncated});
			end
		end
	end

	// Capture read data in the access cycle
	always @(posedge clk) begin
		if (psel && penable && !pwrite && pready)
			cfg_readback <= prdata;
	end

	task automatic push_byte(input logic [zrt_pkg::DATA_W-1:0] ch, input logic eos);
		text_byte_t tb;
		tb.ch = ch;
		tb.eos = eos;
		text_q.push_back(tb);
		if (eos)
			strings_sent++;
	endtask

	// Queue a string of random bytes, with spaces mixed in
	task automatic push_string(input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(7) == 0)
				push_byte(8'h20, i == len - 1);
			else
				push_byte(zrt_pkg::DATA_W'($urandom_range(255)), i == len - 1);
		end
	endtask

	// Hold off the sender until every expected byte is out and the block has settled
	task automatic drain();
		while (text_q.size() != 0 || in_valid || rail_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write num_rows, then read it back
	task automatic set_rails(input logic [zrt_pkg::ROWS_W-1:0] rows);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_NUM_ROWS;
		pwdata <= {{(zrt_pkg::APB_DATA_W - zrt_pkg::ROWS_W){1'b0}}, rows};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		rows_shadow = rows;
		rail_settings++;
		if (cfg_readback !== {{(zrt_pkg::APB_DATA_W - zrt_pkg::ROWS_W){1'b0}}, rows})
			note_mismatch("num_rows readback", {25'h0, rows}, cfg_readback);
	endtask

	initial begin : stimulus
		int unsigned rails_plan [9];
		int unsigned phase_bytes;
		int unsigned len;
		int unsigned roll;
		rails_plan = '{0, 2, 3, 127, 64, 1, 5, 0, 4};
		rails_plan[7] = $urandom_range(127);

		send_idle = 17;
		recv_idle = 54;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// single byte and field extremes with the reset rail count
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h20, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h80, 1'b1);
		drain();

		// three rails, spaces kept as data
		set_rails(7'd3);
		push_byte(8'h20, 1'b0);
		push_byte(8'h20, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'hFE, 1'b0);
		push_byte(8'h20, 1'b0);
		push_byte(8'h33, 1'b1);
		drain();

		// zero rails: burst is empty
		set_rails(7'd0);
		push_byte(8'h11, 1'b0);
		push_byte(8'h22, 1'b0);
		push_byte(8'h33, 1'b1);
		drain();

		// random strings under each rail setting and each idling mode
		for (int p = 0; p < 9; p++) begin
			if (p == 3) begin
				send_idle = 54;
				recv_idle = 17;
			end else if (p == 6) begin
				send_idle = 0;
				recv_idle = 0;
			end
			set_rails(zrt_pkg::ROWS_W'(rails_plan[p]));
			phase_bytes = 0;
			if (p == 1) begin
				push_string(70);
				phase_bytes += 70;
			end else if (p == 4) begin
				push_string(MAX_LEN);
				phase_bytes += MAX_LEN;
			end
			while (phase_bytes < 10) begin
				roll = $urandom_range(99);
				if (roll < 6)
					len = $urandom_range(MAX_LEN + 6, MAX_LEN);
				else if (roll < 20)
					len = $urandom_range(40, 13);
				else
					len = $urandom_range(12, 1);
				push_string(len);
				phase_bytes += len;
			end
			drain();
		end

		$display("covered %0d strings, %0d bytes in and %0d bytes out, %0d with dropped bytes",
			strings_sent, bytes_taken, bytes_out, overflow_strings);
		$display("rail counts written %0d times, mismatches %0d", rail_settings, mismatches);
		if (mismatches == 0 && rail_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Hard stop if the run hangs
	initial begin
		#800000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

/* zigzag_row_transposition_top.f */
design/zrt_pkg.sv
design/zrt_ctrl.sv
design/zrt_dp.sv
design/zigzag_row_transposition_top.sv
tb/zigzag_row_transposition_top_tb.sv
